### sv/rbde_pkg.sv
// Shared constants and types for the run-block dictionary encoder.
package rbde_pkg;

  localparam int SYMBOL_BITS = 24;
  localparam int COUNT_BITS  = 16;
  localparam int LEVEL_BITS  = 8;
  localparam int TABLE_DEPTH = 1024;
  localparam int ADDR_BITS   = $clog2(TABLE_DEPTH);
  localparam int USED_BITS   = $clog2(TABLE_DEPTH + 1);
  localparam int KEY_BITS    = SYMBOL_BITS + COUNT_BITS;
  localparam int CFG_BITS    = 8;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CFG_BITS-1:0] CFG_ID_BASE   = CFG_BITS'(0);
  localparam logic [CFG_BITS-1:0] CFG_LEVEL_TAG = CFG_BITS'(1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef struct packed {
    logic [SYMBOL_BITS-1:0] sym;
    logic [COUNT_BITS-1:0]  len;
    logic                   ovf;
    logic                   burst_last;
    logic                   seq_end;
  } run_event_t;

endpackage

### sv/run_block_dictionary_encoder.sv
// Top level of the run-block dictionary encoder.
//
//   channel  direction  handshake             payload
//   in       request    in_valid / in_stall   symbol_in, stream_last
//   out      result     out_valid / out_stall symbol_out .. count_overflow
//   cfg      write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// The detector stalls the input only when the queue has fewer than two free places.
// A finished run of length one passes the dictionary unit without a search; a longer
// run is compared against the table one entry at a time until its pair is found, the
// pair is new or the table is full, bounded by a search over at most 1024 entries.
// Reset is synchronous and clears the run, the queue and the entry count.
module run_block_dictionary_encoder (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rbde_pkg::SYMBOL_BITS-1:0] symbol_in,
  input  logic                            stream_last,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbde_pkg::SYMBOL_BITS-1:0] symbol_out,
  output logic                            is_new_rule,
  output logic [rbde_pkg::SYMBOL_BITS-1:0] rule_symbol,
  output logic [rbde_pkg::COUNT_BITS-1:0]  rule_count,
  output logic [rbde_pkg::LEVEL_BITS-1:0]  rule_level,
  output logic                            burst_last,
  output logic                            sequence_end,
  output logic                            table_full,
  output logic                            count_overflow,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [rbde_pkg::CFG_BITS-1:0]    cfg_index,
  input  logic [23:0]                     cfg_data
);
  import rbde_pkg::*;

  run_event_t             ev_first, ev_second, head;
  logic [1:0]             ev_count;
  logic                   pop, not_empty, room_for_two, accept;
  logic [SYMBOL_BITS-1:0] id_base;
  logic [LEVEL_BITS-1:0]  level_tag;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room_for_two;
  assign accept    = in_valid && room_for_two;

  always_ff @(posedge clk) begin
    if (rst) begin
      id_base   <= SYMBOL_BITS'(256);
      level_tag <= LEVEL_BITS'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_ID_BASE:   id_base   <= cfg_data[SYMBOL_BITS-1:0];
        CFG_LEVEL_TAG: level_tag <= cfg_data[LEVEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  rbde_front u_front (
    .clk, .rst, .accept, .symbol_in, .stream_last,
    .ev_first, .ev_second, .ev_count
  );

  rbde_queue u_queue (
    .clk, .rst, .push_first(ev_first), .push_second(ev_second),
    .push_count(ev_count), .pop, .head, .not_empty, .room_for_two
  );

  rbde_back u_back (
    .clk, .rst, .head, .not_empty, .pop, .id_base, .level_tag,
    .out_valid, .out_stall, .symbol_out, .is_new_rule, .rule_symbol,
    .rule_count, .rule_level, .burst_last, .sequence_end, .table_full,
    .count_overflow
  );
endmodule

### sv/rbde_front.sv
// Run detector: tracks the open run and turns each finished run into queue requests.
module rbde_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  logic [rbde_pkg::SYMBOL_BITS-1:0] symbol_in,
  input  logic                            stream_last,
  output rbde_pkg::run_event_t            ev_first,
  output rbde_pkg::run_event_t            ev_second,
  output logic [1:0]                      ev_count
);
  import rbde_pkg::*;

  logic [SYMBOL_BITS-1:0] run_symbol, sym_next;
  logic [COUNT_BITS-1:0]  run_length, len_next;
  logic                   run_open, overflow_seen, ovf_next, same, push_old;
  run_event_t             ev_old, ev_new;

  always_comb begin
    same     = run_open && (symbol_in == run_symbol);
    push_old = run_open && !same;
    if (same) begin
      sym_next = run_symbol;
      len_next = (run_length == COUNT_MAX) ? run_length : run_length + COUNT_BITS'(1);
      ovf_next = overflow_seen || (run_length == COUNT_MAX);
    end else begin
      sym_next = symbol_in;
      len_next = COUNT_BITS'(1);
      ovf_next = 1'b0;
    end
    ev_old = '{sym: run_symbol, len: run_length, ovf: overflow_seen,
               burst_last: !stream_last, seq_end: 1'b0};
    ev_new = '{sym: sym_next, len: len_next, ovf: ovf_next,
               burst_last: 1'b1, seq_end: 1'b1};
    ev_second = ev_new;
    if (push_old) begin
      ev_first = ev_old;
      ev_count = stream_last ? 2'd2 : 2'd1;
    end else begin
      ev_first = ev_new;
      ev_count = stream_last ? 2'd1 : 2'd0;
    end
    if (!accept) begin
      ev_count = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run_symbol    <= '0;
      run_length    <= '0;
      run_open      <= 1'b0;
      overflow_seen <= 1'b0;
    end else if (accept) begin
      if (stream_last) begin
        run_symbol    <= '0;
        run_length    <= '0;
        run_open      <= 1'b0;
        overflow_seen <= 1'b0;
      end else begin
        run_symbol    <= sym_next;
        run_length    <= len_next;
        run_open      <= 1'b1;
        overflow_seen <= ovf_next;
      end
    end
  end
endmodule

### sv/rbde_queue.sv
// Short queue of finished runs between the run detector and the dictionary unit.
module rbde_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  rbde_pkg::run_event_t push_first,
  input  rbde_pkg::run_event_t push_second,
  input  logic [1:0]           push_count,
  input  logic                 pop,
  output rbde_pkg::run_event_t head,
  output logic                 not_empty,
  output logic                 room_for_two
);
  import rbde_pkg::*;

  run_event_t             slots [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0]   wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0]   count;

  assign head         = slots[rd_ptr];
  assign not_empty    = (count != '0);
  assign room_for_two = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push_first;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr + QPTR_BITS'(1)] <= push_second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push_count);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count + QCNT_BITS'(push_count) - QCNT_BITS'(pop);
    end
  end
endmodule

### sv/rbde_back.sv
// Dictionary unit: searches the pair table one entry at a time and drives the result register.
module rbde_back (
  input  logic                            clk,
  input  logic                            rst,
  input  rbde_pkg::run_event_t            head,
  input  logic                            not_empty,
  output logic                            pop,
  input  logic [rbde_pkg::SYMBOL_BITS-1:0] id_base,
  input  logic [rbde_pkg::LEVEL_BITS-1:0]  level_tag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [rbde_pkg::SYMBOL_BITS-1:0] symbol_out,
  output logic                            is_new_rule,
  output logic [rbde_pkg::SYMBOL_BITS-1:0] rule_symbol,
  output logic [rbde_pkg::COUNT_BITS-1:0]  rule_count,
  output logic [rbde_pkg::LEVEL_BITS-1:0]  rule_level,
  output logic                            burst_last,
  output logic                            sequence_end,
  output logic                            table_full,
  output logic                            count_overflow
);
  import rbde_pkg::*;

  typedef enum logic [1:0] {IDLE, READ, COMPARE, EMIT} state_t;
  typedef enum logic [1:0] {PASS, FOUND, CREATE, FULL} kind_t;

  state_t                 state;
  kind_t                  kind;
  run_event_t             cur;
  logic [USED_BITS-1:0]   idx, used;
  logic [KEY_BITS-1:0]    dict [TABLE_DEPTH];
  logic [KEY_BITS-1:0]    rdata, key;
  logic                   slot_free;
  logic [SYMBOL_BITS-1:0] id_value;

  assign key       = {cur.sym, cur.len};
  assign slot_free = !out_valid || !out_stall;
  assign pop       = (state == IDLE) && not_empty;

  always_comb begin
    case (kind)
      PASS:    id_value = cur.sym;
      FOUND:   id_value = id_base + SYMBOL_BITS'(idx);
      CREATE:  id_value = id_base + SYMBOL_BITS'(used);
      default: id_value = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    rdata <= dict[idx[ADDR_BITS-1:0]];
    if (state == EMIT && slot_free && kind == CREATE) begin
      dict[used[ADDR_BITS-1:0]] <= key;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
      used      <= '0;
      idx       <= '0;
      kind      <= PASS;
    end else begin
      case (state)
        IDLE: begin
          if (not_empty) begin
            cur  <= head;
            idx  <= '0;
            kind <= PASS;
            state <= (head.len <= COUNT_BITS'(1)) ? EMIT : READ;
          end
        end
        READ: begin
          if (idx == used) begin
            kind  <= (used == USED_BITS'(TABLE_DEPTH)) ? FULL : CREATE;
            state <= EMIT;
          end else begin
            state <= COMPARE;
          end
        end
        COMPARE: begin
          if (rdata == key) begin
            kind  <= FOUND;
            state <= EMIT;
          end else begin
            idx   <= idx + USED_BITS'(1);
            state <= READ;
          end
        end
        EMIT: begin
          if (slot_free) begin
            state <= IDLE;
            if (cur.seq_end) begin
              used <= '0;
            end else if (kind == CREATE) begin
              used <= used + USED_BITS'(1);
            end
          end
        end
        default: state <= IDLE;
      endcase

      if (state == EMIT && slot_free) begin
        out_valid      <= 1'b1;
        symbol_out     <= id_value;
        is_new_rule    <= (kind == CREATE);
        rule_symbol    <= (kind == CREATE) ? cur.sym : '0;
        rule_count     <= (kind == CREATE) ? cur.len : '0;
        rule_level     <= (kind == CREATE) ? level_tag : '0;
        burst_last     <= cur.burst_last;
        sequence_end   <= cur.seq_end;
        table_full     <= (kind == FULL);
        count_overflow <= cur.ovf;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end
endmodule

### sv/rbde_checker.sv
// Port-level checks for the run-block dictionary encoder, bound to the top level.
module rbde_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_stall,
  input logic [rbde_pkg::SYMBOL_BITS-1:0] symbol_out,
  input logic                            is_new_rule,
  input logic [rbde_pkg::COUNT_BITS-1:0]  rule_count,
  input logic                            burst_last,
  input logic                            sequence_end,
  input logic                            table_full
);
  import rbde_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("Stalled result was withdrawn.");

  a_end_closes_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && sequence_end |-> burst_last)
    else $error("Sequence end on a result that is not last of its burst.");

  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && table_full |-> !is_new_rule && symbol_out == '0)
    else $error("Table-full result carries an id or a new rule.");

  a_rule_len: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_new_rule |-> rule_count > COUNT_BITS'(1))
    else $error("New rule with a run length below two.");
endmodule

bind run_block_dictionary_encoder rbde_checker u_rbde_checker (
  .clk, .rst, .out_valid, .out_stall, .symbol_out, .is_new_rule,
  .rule_count, .burst_last, .sequence_end, .table_full
);
